FILE: hw/rtl/psv_pkg.sv
// Shared types, constants and helpers of the pitched sample voice.
`default_nettype none

package psv_pkg;

   localparam int DENOM      = 32768;
   localparam int FRAC_W     = 15;
   localparam int RAMP_NUM   = 100;
   localparam int RAMP_RATE  = 44100;

   localparam int KIND_W     = 2;
   localparam int ADDR_W     = 17;
   localparam int SAMPLE_W   = 16;
   localparam int COUNT_W    = 16;
   localparam int PITCH_W    = 18;
   localparam int GAIN_W     = 16;
   localparam int POS_W      = 17;
   localparam int CHAN_W     = 2;
   localparam int IDX_W      = 18;
   localparam int PROD_W     = COUNT_W + PITCH_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int MOD_VAL_W  = SUM_W - FRAC_W + 1;
   localparam int ACC_W      = 32;
   localparam int LV_W       = ACC_W - FRAC_W;
   localparam int MG_W       = LV_W + GAIN_W + 1;
   localparam int Q_W        = MG_W - FRAC_W;
   localparam int MIN_MEM_AW = 10;
   localparam int RED_STEPS  = IDX_W - MIN_MEM_AW;

   localparam int SMP_MAX    = 32767;
   localparam int SMP_MIN    = -32768;

   localparam int Q_DEPTH    = 4;
   localparam int Q_PTR_W    = 2;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;

   localparam logic [GAIN_W-1:0] RAMP_STEP = GAIN_W'(DENOM * RAMP_NUM / RAMP_RATE);
   localparam logic [POS_W-1:0]  POS_MAX   = '1;

   typedef enum logic [KIND_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_TICK  = 2'd1,
      OP_START = 2'd2,
      OP_SKIP  = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PITCH_STEP  = 3'd0,
      CSR_GAIN_LEFT   = 3'd1,
      CSR_GAIN_RIGHT  = 3'd2,
      CSR_LOOP_ENABLE = 3'd3,
      CSR_FRAME_COUNT = 3'd4,
      CSR_CHAN_COUNT  = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_SKIP,
      B_TMOD,
      B_READ,
      B_RDWAIT,
      B_LERP,
      B_SETTLE,
      B_WRAP,
      B_OUT
   } back_state_type;

   typedef struct packed {
      logic [PITCH_W-1:0] pitch_step;
      logic [GAIN_W-1:0]  gain_left_target;
      logic [GAIN_W-1:0]  gain_right_target;
      logic               loop_enable;
      logic [POS_W-1:0]   frame_count;
      logic [CHAN_W-1:0]  channel_count;
   } cfg_type;

   typedef struct packed {
      op_type               op;
      logic [ADDR_W-1:0]    addr;
      logic [SAMPLE_W-1:0]  data;
      logic [COUNT_W-1:0]   count;
   } item_type;

   typedef struct packed {
      logic                 start;
      logic [MOD_VAL_W-1:0] value;
      logic [POS_W-1:0]     divisor;
   } mod_req_type;

   typedef struct packed {
      logic             done;
      logic [POS_W-1:0] rem;
   } mod_rsp_type;

   function automatic logic [GAIN_W-1:0] ramp(input logic [GAIN_W-1:0] now,
                                              input logic [GAIN_W-1:0] target);
      logic [GAIN_W-1:0] diff;
      if (target > now) begin
         diff = target - now;
         return now + ((diff < RAMP_STEP) ? diff : RAMP_STEP);
      end
      diff = now - target;
      return now - ((diff < RAMP_STEP) ? diff : RAMP_STEP);
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/psv_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module psv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/psv_front.sv
// Request intake: accepts words, decodes the kind and queues them for the back end.
`default_nettype none

module psv_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire logic [psv_pkg::KIND_W-1:0]      req_kind,
   input  wire logic [psv_pkg::ADDR_W-1:0]      req_load_address,
   input  wire logic signed [psv_pkg::SAMPLE_W-1:0] req_load_data,
   input  wire logic [psv_pkg::COUNT_W-1:0]     req_skip_count,
   output      logic                            q_valid,
   output      psv_pkg::item_type               q_item,
   input  wire logic                            q_pop
);

   psv_pkg::item_type               entry_ff [psv_pkg::Q_DEPTH];
   psv_pkg::item_type               item_in;
   logic [psv_pkg::Q_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [psv_pkg::Q_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [psv_pkg::Q_PTR_W:0]       fill_ff, fill_in;
   logic                            push;

   always_comb begin
      item_in.op    = psv_pkg::op_type'(req_kind);
      item_in.addr  = req_load_address;
      item_in.data  = req_load_data;
      item_in.count = req_skip_count;
   end

   assign req_stall = (fill_ff == (psv_pkg::Q_PTR_W + 1)'(psv_pkg::Q_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (fill_ff != '0);
   assign q_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && q_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/psv_mod.sv
// Iterative remainder unit, one quotient bit per cycle with a fast path for small values.
`default_nettype none

module psv_mod (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire psv_pkg::mod_req_type mod_req,
   output      psv_pkg::mod_rsp_type mod_rsp
);

   localparam int CNT_W = $clog2(psv_pkg::MOD_VAL_W);

   logic [psv_pkg::MOD_VAL_W-1:0] val_ff, val_in;
   logic [psv_pkg::POS_W-1:0]     rem_ff, rem_in;
   logic [psv_pkg::POS_W-1:0]     div_ff, div_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [psv_pkg::POS_W:0]       shifted;

   assign shifted = {rem_ff, val_ff[psv_pkg::MOD_VAL_W-1]};

   always_comb begin
      val_in  = val_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (mod_req.start) begin
         div_in = mod_req.divisor;
         if (mod_req.value < psv_pkg::MOD_VAL_W'(mod_req.divisor)) begin
            rem_in  = mod_req.value[psv_pkg::POS_W-1:0];
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            val_in  = mod_req.value;
            rem_in  = '0;
            cnt_in  = CNT_W'(psv_pkg::MOD_VAL_W - 1);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (shifted >= (psv_pkg::POS_W + 1)'(div_ff)) begin
            rem_in = psv_pkg::POS_W'(shifted - (psv_pkg::POS_W + 1)'(div_ff));
         end else begin
            rem_in = shifted[psv_pkg::POS_W-1:0];
         end
         val_in = {val_ff[psv_pkg::MOD_VAL_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
   end

   assign mod_rsp.done = done_ff;
   assign mod_rsp.rem  = rem_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/psv_back.sv
// Execution back end: sample memory, gain ramp, interpolation, position update, output register.
`default_nettype none

module psv_back #(
   parameter int MEMORY_WORDS = 131072
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire psv_pkg::cfg_type         cfg,
   input  wire logic                     q_valid,
   input  wire psv_pkg::item_type        q_item,
   output      logic                     q_pop,
   output      psv_pkg::mod_req_type     mod_req,
   input  wire psv_pkg::mod_rsp_type     mod_rsp,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      logic signed [psv_pkg::SAMPLE_W-1:0] rsp_left_out,
   output      logic signed [psv_pkg::SAMPLE_W-1:0] rsp_right_out,
   output      logic                     rsp_still_playing
);

   localparam int MEM_AW = $clog2(MEMORY_WORDS);
   localparam int RED_W  = MEM_AW + psv_pkg::RED_STEPS;
   localparam int SW     = psv_pkg::SAMPLE_W;
   localparam logic signed [psv_pkg::Q_W-1:0] Q_HI = psv_pkg::Q_W'(psv_pkg::SMP_MAX);
   localparam logic signed [psv_pkg::Q_W-1:0] Q_LO = psv_pkg::Q_W'(psv_pkg::SMP_MIN);

   function automatic logic [MEM_AW-1:0] mem_wrap(input logic [psv_pkg::IDX_W-1:0] v);
      logic [RED_W-1:0] r;
      logic [RED_W-1:0] m;
      r = RED_W'(v);
      for (int k = psv_pkg::RED_STEPS - 1; k >= 0; k--) begin
         m = RED_W'(MEMORY_WORDS) << k;
         if (r >= m) begin
            r = r - m;
         end
      end
      return r[MEM_AW-1:0];
   endfunction

   psv_pkg::back_state_type state_ff, state_in;

   logic                            is_tick_ff, is_tick_in;
   logic                            playing_ff, playing_in;
   logic [psv_pkg::POS_W-1:0]       pos_ff, pos_in;
   logic [psv_pkg::FRAC_W-1:0]      frac_ff, frac_in;
   logic [psv_pkg::GAIN_W-1:0]      gain_l_ff, gain_l_in;
   logic [psv_pkg::GAIN_W-1:0]      gain_r_ff, gain_r_in;
   logic [psv_pkg::PROD_W-1:0]      prod_ff, prod_in;
   logic [psv_pkg::SUM_W-1:0]       sum_ff, sum_in;
   logic [psv_pkg::IDX_W-1:0]       id1_ff, id1_in;
   logic [psv_pkg::IDX_W-1:0]       id2_ff, id2_in;
   logic [1:0]                      rd_cnt_ff, rd_cnt_in;
   logic                            rd_pend_ff, rd_pend_in;
   logic [1:0]                      rd_idx_ff, rd_idx_in;
   logic signed [SW-1:0]            smp_ff [4];
   logic signed [SW-1:0]            smp_in [4];
   logic [2:0]                      step_ff, step_in;
   logic                            lane_ff, lane_in;
   logic signed [psv_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic signed [psv_pkg::LV_W-1:0] lv_ff, lv_in;
   logic signed [psv_pkg::MG_W-1:0] mg_ff, mg_in;
   logic signed [SW-1:0]            res_l_ff, res_l_in;
   logic signed [SW-1:0]            res_r_ff, res_r_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0]            rsp_l_ff, rsp_l_in;
   logic signed [SW-1:0]            rsp_r_ff, rsp_r_in;
   logic                            rsp_play_ff, rsp_play_in;

   logic [psv_pkg::POS_W-1:0]       fc_eff;
   logic                            stereo;
   logic [psv_pkg::IDX_W-1:0]       total;
   logic [psv_pkg::IDX_W-1:0]       inc;
   logic [psv_pkg::IDX_W-1:0]       id1_calc;
   logic [psv_pkg::IDX_W-1:0]       id2_raw;
   logic [psv_pkg::IDX_W-1:0]       id2_calc;
   logic [psv_pkg::IDX_W-1:0]       rd_sel;
   logic [psv_pkg::MOD_VAL_W-1:0]   newpos;
   logic [psv_pkg::POS_W-1:0]       pos_sat;
   logic signed [SW-1:0]            smp_a;
   logic signed [SW-1:0]            smp_b;
   logic [psv_pkg::GAIN_W-1:0]      gain_sel;
   logic [psv_pkg::FRAC_W:0]        wfrac;
   logic signed [psv_pkg::ACC_W-1:0] mul_b;
   logic signed [psv_pkg::ACC_W:0]  mul_a;
   logic signed [psv_pkg::ACC_W-1:0] acc_round;
   logic signed [psv_pkg::MG_W-1:0] mul_g;
   logic signed [psv_pkg::MG_W-1:0] mg_round;
   logic signed [psv_pkg::Q_W-1:0]  q_sc;
   logic signed [SW-1:0]            q_sat;

   logic                            mem_we;
   logic [MEM_AW-1:0]               mem_waddr;
   logic                            mem_re;
   logic [MEM_AW-1:0]               mem_raddr;
   logic [SW-1:0]                   mem_rdata;

   psv_ram #(
      .WIDTH (SW),
      .DEPTH (MEMORY_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (q_item.data),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign fc_eff   = (cfg.frame_count == '0) ? psv_pkg::POS_W'(1) : cfg.frame_count;
   assign stereo   = cfg.channel_count[1];
   assign total    = stereo ? {fc_eff, 1'b0} : {1'b0, fc_eff};
   assign inc      = psv_pkg::IDX_W'(stereo);
   assign id1_calc = stereo ? {mod_rsp.rem, 1'b0} : {1'b0, mod_rsp.rem};
   assign id2_raw  = id1_calc + inc + psv_pkg::IDX_W'(1);
   assign id2_calc = (id2_raw >= total) ? id2_raw - total : id2_raw;

   always_comb begin
      case (rd_cnt_ff)
         2'd0:    rd_sel = id1_ff;
         2'd1:    rd_sel = id2_ff;
         2'd2:    rd_sel = id1_ff + inc;
         default: rd_sel = id2_ff + inc;
      endcase
   end

   assign newpos  = psv_pkg::MOD_VAL_W'(pos_ff)
                  + psv_pkg::MOD_VAL_W'(sum_ff[psv_pkg::SUM_W-1:psv_pkg::FRAC_W]);
   assign pos_sat = (newpos > psv_pkg::MOD_VAL_W'(psv_pkg::POS_MAX)) ? psv_pkg::POS_MAX
                  : newpos[psv_pkg::POS_W-1:0];

   assign smp_a    = lane_ff ? smp_ff[2] : smp_ff[0];
   assign smp_b    = lane_ff ? smp_ff[3] : smp_ff[1];
   assign gain_sel = lane_ff ? gain_r_ff : gain_l_ff;
   assign wfrac    = (psv_pkg::FRAC_W + 1)'(psv_pkg::DENOM) - (psv_pkg::FRAC_W + 1)'(frac_ff);

   assign mul_b     = $signed({1'b0, frac_ff}) * smp_b;
   assign mul_a     = $signed({1'b0, wfrac}) * smp_a;
   assign acc_round = acc_ff + (acc_ff[psv_pkg::ACC_W-1]
                    ? psv_pkg::ACC_W'(psv_pkg::DENOM - 1) : psv_pkg::ACC_W'(0));
   assign mul_g     = lv_ff * $signed({1'b0, gain_sel});
   assign mg_round  = mg_ff + (mg_ff[psv_pkg::MG_W-1]
                    ? psv_pkg::MG_W'(psv_pkg::DENOM - 1) : psv_pkg::MG_W'(0));
   assign q_sc      = mg_round[psv_pkg::MG_W-1:psv_pkg::FRAC_W];

   always_comb begin
      if (q_sc > Q_HI) begin
         q_sat = SW'(psv_pkg::SMP_MAX);
      end else if (q_sc < Q_LO) begin
         q_sat = SW'(psv_pkg::SMP_MIN);
      end else begin
         q_sat = q_sc[SW-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      is_tick_in   = is_tick_ff;
      playing_in   = playing_ff;
      pos_in       = pos_ff;
      frac_in      = frac_ff;
      gain_l_in    = gain_l_ff;
      gain_r_in    = gain_r_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      id1_in       = id1_ff;
      id2_in       = id2_ff;
      rd_cnt_in    = rd_cnt_ff;
      rd_pend_in   = 1'b0;
      rd_idx_in    = rd_idx_ff;
      smp_in       = smp_ff;
      step_in      = step_ff;
      lane_in      = lane_ff;
      acc_in       = acc_ff;
      lv_in        = lv_ff;
      mg_in        = mg_ff;
      res_l_in     = res_l_ff;
      res_r_in     = res_r_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_l_in     = rsp_l_ff;
      rsp_r_in     = rsp_r_ff;
      rsp_play_in  = rsp_play_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = mem_wrap(psv_pkg::IDX_W'(q_item.addr));
      mem_re       = 1'b0;
      mem_raddr    = mem_wrap(rd_sel);
      mod_req.start   = 1'b0;
      mod_req.value   = psv_pkg::MOD_VAL_W'(pos_ff);
      mod_req.divisor = fc_eff;

      if (rd_pend_ff) begin
         smp_in[rd_idx_ff] = mem_rdata;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         psv_pkg::B_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b0;
               q_pop = 1'b1;
               case (q_item.op)
                  psv_pkg::OP_LOAD: begin
                     mem_we = 1'b1;
                  end
                  psv_pkg::OP_START: begin
                     pos_in     = '0;
                     frac_in    = '0;
                     playing_in = 1'b1;
                  end
                  psv_pkg::OP_SKIP: begin
                     is_tick_in = 1'b0;
                     prod_in    = psv_pkg::PROD_W'(q_item.count)
                                * psv_pkg::PROD_W'(cfg.pitch_step);
                     state_in   = psv_pkg::B_SKIP;
                  end
                  default: begin
                     is_tick_in = 1'b1;
                     res_l_in   = '0;
                     res_r_in   = '0;
                     if (!playing_ff) begin
                        state_in = psv_pkg::B_OUT;
                     end else begin
                        gain_l_in = psv_pkg::ramp(gain_l_ff, cfg.gain_left_target);
                        gain_r_in = psv_pkg::ramp(gain_r_ff, cfg.gain_right_target);
                        if (!cfg.loop_enable && (pos_ff >= fc_eff)) begin
                           playing_in = 1'b0;
                           state_in   = psv_pkg::B_OUT;
                        end else begin
                           mod_req.start = 1'b1;
                           sum_in        = psv_pkg::SUM_W'(frac_ff)
                                         + psv_pkg::SUM_W'(cfg.pitch_step);
                           state_in      = psv_pkg::B_TMOD;
                        end
                     end
                  end
               endcase
            end
         end
         psv_pkg::B_SKIP: begin
            sum_in   = psv_pkg::SUM_W'(frac_ff) + psv_pkg::SUM_W'(prod_ff);
            state_in = psv_pkg::B_SETTLE;
         end
         psv_pkg::B_TMOD: begin
            if (mod_rsp.done) begin
               id1_in    = id1_calc;
               id2_in    = id2_calc;
               rd_cnt_in = '0;
               state_in  = psv_pkg::B_READ;
            end
         end
         psv_pkg::B_READ: begin
            mem_re     = 1'b1;
            rd_pend_in = 1'b1;
            rd_idx_in  = rd_cnt_ff;
            rd_cnt_in  = rd_cnt_ff + 1'b1;
            if (rd_cnt_ff == 2'd3) begin
               state_in = psv_pkg::B_RDWAIT;
            end
         end
         psv_pkg::B_RDWAIT: begin
            step_in  = '0;
            lane_in  = 1'b0;
            state_in = psv_pkg::B_LERP;
         end
         psv_pkg::B_LERP: begin
            step_in = step_ff + 1'b1;
            case (step_ff)
               3'd0: acc_in = mul_b;
               3'd1: acc_in = acc_ff + mul_a[psv_pkg::ACC_W-1:0];
               3'd2: lv_in  = acc_round[psv_pkg::ACC_W-1:psv_pkg::FRAC_W];
               3'd3: mg_in  = mul_g;
               default: begin
                  step_in = '0;
                  if (lane_ff) begin
                     res_r_in = q_sat;
                     state_in = psv_pkg::B_SETTLE;
                  end else begin
                     res_l_in = q_sat;
                     lane_in  = 1'b1;
                  end
               end
            endcase
         end
         psv_pkg::B_SETTLE: begin
            frac_in = sum_ff[psv_pkg::FRAC_W-1:0];
            if (cfg.loop_enable) begin
               mod_req.start = 1'b1;
               mod_req.value = newpos;
               state_in      = psv_pkg::B_WRAP;
            end else begin
               playing_in = playing_ff && (newpos < psv_pkg::MOD_VAL_W'(fc_eff));
               pos_in     = pos_sat;
               state_in   = is_tick_ff ? psv_pkg::B_OUT : psv_pkg::B_IDLE;
            end
         end
         psv_pkg::B_WRAP: begin
            if (mod_rsp.done) begin
               pos_in   = mod_rsp.rem;
               state_in = is_tick_ff ? psv_pkg::B_OUT : psv_pkg::B_IDLE;
            end
         end
         psv_pkg::B_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_l_in     = res_l_ff;
               rsp_r_in     = res_r_ff;
               rsp_play_in  = playing_ff;
               state_in     = psv_pkg::B_IDLE;
            end
         end
         default: begin
            state_in = psv_pkg::B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psv_pkg::B_IDLE;
         playing_ff   <= 1'b0;
         pos_ff       <= '0;
         frac_ff      <= '0;
         gain_l_ff    <= '0;
         gain_r_ff    <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         playing_ff   <= playing_in;
         pos_ff       <= pos_in;
         frac_ff      <= frac_in;
         gain_l_ff    <= gain_l_in;
         gain_r_ff    <= gain_r_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_tick_ff  <= is_tick_in;
      prod_ff     <= prod_in;
      sum_ff      <= sum_in;
      id1_ff      <= id1_in;
      id2_ff      <= id2_in;
      rd_cnt_ff   <= rd_cnt_in;
      rd_idx_ff   <= rd_idx_in;
      smp_ff      <= smp_in;
      step_ff     <= step_in;
      lane_ff     <= lane_in;
      acc_ff      <= acc_in;
      lv_ff       <= lv_in;
      mg_ff       <= mg_in;
      res_l_ff    <= res_l_in;
      res_r_ff    <= res_r_in;
      rsp_l_ff    <= rsp_l_in;
      rsp_r_ff    <= rsp_r_in;
      rsp_play_ff <= rsp_play_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_left_out      = rsp_l_ff;
   assign rsp_right_out     = rsp_r_ff;
   assign rsp_still_playing = rsp_play_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/pitched_sample_voice.sv
// Top level of the pitched sample voice: register file, intake queue, remainder unit, back end.
//
//   channel | ports                       | handshake       | word
//   --------+-----------------------------+-----------------+--------------------------------
//   request | req_*                       | valid / stall   | kind, address, data, skip count
//   result  | rsp_*                       | valid / stall   | left, right, still playing
//   config  | csr_*                       | write enable    | index, data
//
// In the back end, load and start complete in the idle state and an idle or stopping tick
// goes straight to the output state; the remainder unit iterates only for a value at or above
// the frame count, both for the frame wrap before the read and for the loop wrap.
// Request words queue in a 4-deep buffer, so intake keeps going while the back end works.
// Synchronous active high reset; the sample memory is not cleared.
// A stalled result sits in the output register; the back end holds its next result until it drains.
`default_nettype none

module pitched_sample_voice #(
   parameter int MEMORY_WORDS = 131072
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic [psv_pkg::KIND_W-1:0]          req_kind,
   input  wire logic [psv_pkg::ADDR_W-1:0]          req_load_address,
   input  wire logic signed [psv_pkg::SAMPLE_W-1:0] req_load_data,
   input  wire logic [psv_pkg::COUNT_W-1:0]         req_skip_count,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic signed [psv_pkg::SAMPLE_W-1:0] rsp_left_out,
   output      logic signed [psv_pkg::SAMPLE_W-1:0] rsp_right_out,
   output      logic                                rsp_still_playing,
   input  wire logic                                csr_write_enable,
   input  wire logic [psv_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [psv_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   psv_pkg::cfg_type     cfg_ff, cfg_in;
   logic                 q_valid;
   psv_pkg::item_type    q_item;
   logic                 q_pop;
   psv_pkg::mod_req_type mod_req;
   psv_pkg::mod_rsp_type mod_rsp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            psv_pkg::CSR_PITCH_STEP:  cfg_in.pitch_step        = csr_wdata;
            psv_pkg::CSR_GAIN_LEFT:   cfg_in.gain_left_target  = csr_wdata[psv_pkg::GAIN_W-1:0];
            psv_pkg::CSR_GAIN_RIGHT:  cfg_in.gain_right_target = csr_wdata[psv_pkg::GAIN_W-1:0];
            psv_pkg::CSR_LOOP_ENABLE: cfg_in.loop_enable       = csr_wdata[0];
            psv_pkg::CSR_FRAME_COUNT: cfg_in.frame_count       = csr_wdata[psv_pkg::POS_W-1:0];
            psv_pkg::CSR_CHAN_COUNT:  cfg_in.channel_count     = csr_wdata[psv_pkg::CHAN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pitch_step        <= psv_pkg::PITCH_W'(psv_pkg::DENOM);
         cfg_ff.gain_left_target  <= psv_pkg::GAIN_W'(psv_pkg::DENOM);
         cfg_ff.gain_right_target <= psv_pkg::GAIN_W'(psv_pkg::DENOM);
         cfg_ff.loop_enable       <= 1'b0;
         cfg_ff.frame_count       <= psv_pkg::POS_W'(1);
         cfg_ff.channel_count     <= psv_pkg::CHAN_W'(2);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   psv_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_load_address (req_load_address),
      .req_load_data    (req_load_data),
      .req_skip_count   (req_skip_count),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop)
   );

   psv_mod u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   psv_back #(
      .MEMORY_WORDS (MEMORY_WORDS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .mod_req           (mod_req),
      .mod_rsp           (mod_rsp),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_left_out      (rsp_left_out),
      .rsp_right_out     (rsp_right_out),
      .rsp_still_playing (rsp_still_playing)
   );

endmodule

`default_nettype wire
